// ----- src/pipc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_pkg: shared types and constants
// Coordinate widths, controller-to-datapath command and status records.
// ----------------------------------------------------------------------------
`default_nettype none

package pipc_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int DIFF_WIDTH     = COORD_WIDTH + 1;      // difference of two coordinates
   localparam int PROD_WIDTH     = 2 * DIFF_WIDTH;       // product of two differences
   localparam int REQ_DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = 8;
   localparam int DIV_CNT_WIDTH  = $clog2(PROD_WIDTH);

   localparam logic [1:0] SEEN_FULL = 2'd3;              // vertex count saturates here

   localparam logic OP_START  = 1'b0;
   localparam logic OP_VERTEX = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   typedef enum logic {
      EDGE_PREV_CUR,
      EDGE_CUR_FIRST
   } edge_sel_type;

   typedef struct packed {
      logic         load;          // capture an accepted item
      logic         start_query;   // load test point, clear polygon state
      logic         setup;         // latch edge differences and range flags
      edge_sel_type sel;
      logic         mul;           // form (ty - ay) * (bx - ax)
      logic         toggle;        // vertical edge crossing
      logic         div_start;
      logic         cmp;           // compare test x against crossing
      logic         update;        // advance first/prev/count
      logic         emit;          // load result register
   } dp_cmd_type;

   typedef struct packed {
      logic op;
      logic last;
      logic seen_zero;
      logic edge_hit;
      logic edge_vert;
      logic div_done;
      logic rsp_full;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- src/pipc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_div: bit-serial signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module pipc_div
   import pipc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire prod_type num,
   input  wire diff_type den,
   output logic          done,
   output prod_type      quo
);

   localparam logic [DIV_CNT_WIDTH-1:0] CNT_LAST = DIV_CNT_WIDTH'(PROD_WIDTH - 1);

   logic                     busy_ff, busy_in;
   logic                     fix_ff, fix_in;
   logic                     done_ff, done_in;
   logic                     neg_ff, neg_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DIFF_WIDTH-1:0]    rem_ff, rem_in;
   logic [DIFF_WIDTH-1:0]    den_ff, den_in;
   logic [PROD_WIDTH-1:0]    sh_ff, sh_in;
   prod_type                 quo_ff, quo_in;

   logic [DIFF_WIDTH:0]      trial;
   logic [DIFF_WIDTH+1:0]    diff;
   logic                     ge;

   assign trial = {rem_ff, sh_ff[PROD_WIDTH-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};
   assign ge    = ~diff[DIFF_WIDTH+1];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         sh_in   = num[PROD_WIDTH-1] ? -num : num;
         den_in  = den[DIFF_WIDTH-1] ? -den : den;
         neg_in  = num[PROD_WIDTH-1] ^ den[DIFF_WIDTH-1];
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIFF_WIDTH-1:0] : trial[DIFF_WIDTH-1:0];
         sh_in  = {sh_ff[PROD_WIDTH-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end
      // sign of the quotient applied after the last quotient bit, in a registered step of its own
      if (fix_ff) begin
         done_in = 1'b1;
         quo_in  = neg_ff ? -sh_ff : sh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// ----- src/pipc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_dp: polygon test datapath
// Point and vertex registers, edge setup, multiplier, divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pipc_dp
   import pipc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dp_cmd_type                cmd,
   output dp_status_type                  status,
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  wire logic                      req_tuser,
   input  wire logic                      req_tlast,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,
   output logic                           rsp_tuser
);

   coord_type  test_x_ff, test_y_ff, first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   coord_type  cur_x_ff, cur_y_ff, ax_ff;
   logic       op_ff, last_ff;
   logic       parity_ff, parity_in;
   logic [1:0] seen_ff, seen_in;
   logic       hit_ff, vert_ff;
   diff_type   dyt_ff, dxw_ff, dy_ff;
   prod_type   prod_ff;
   logic       rsp_valid_ff, inside_ff, too_few_ff;

   coord_type  ax, ay, bx, by, lo_y, hi_y, hi_x;
   logic       hit;
   logic       div_done;
   prod_type   quo, cross_x, tx_ext;

   // edge endpoints
   always_comb begin
      unique case (cmd.sel)
         EDGE_PREV_CUR: begin
            ax = prev_x_ff;
            ay = prev_y_ff;
            bx = cur_x_ff;
            by = cur_y_ff;
         end
         EDGE_CUR_FIRST: begin
            ax = cur_x_ff;
            ay = cur_y_ff;
            bx = first_x_ff;
            by = first_y_ff;
         end
         default: begin
            ax = prev_x_ff;
            ay = prev_y_ff;
            bx = cur_x_ff;
            by = cur_y_ff;
         end
      endcase
   end

   assign lo_y = (ay < by) ? ay : by;
   assign hi_y = (ay < by) ? by : ay;
   assign hi_x = (ax < bx) ? bx : ax;
   assign hit  = (test_y_ff > lo_y) && (test_y_ff <= hi_y) && (test_x_ff <= hi_x);

   pipc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (prod_ff),
      .den   (dy_ff),
      .done  (div_done),
      .quo   (quo)
   );

   assign cross_x = quo + PROD_WIDTH'(ax_ff);
   assign tx_ext  = PROD_WIDTH'(test_x_ff);

   always_comb begin
      parity_in = parity_ff;
      seen_in   = seen_ff;
      priority if (cmd.start_query || cmd.emit) begin
         parity_in = 1'b0;
         seen_in   = 2'd0;
      end else if (cmd.toggle) begin
         parity_in = ~parity_ff;
      end else if (cmd.cmp) begin
         parity_in = parity_ff ^ (tx_ext <= cross_x);
      end else if (cmd.update) begin
         seen_in = (seen_ff == SEEN_FULL) ? SEEN_FULL : seen_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         test_x_ff    <= '0;
         test_y_ff    <= '0;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         parity_ff    <= 1'b0;
         seen_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         parity_ff <= parity_in;
         seen_ff   <= seen_in;
         if (cmd.start_query) begin
            test_x_ff <= cur_x_ff;
            test_y_ff <= cur_y_ff;
         end
         if (cmd.update) begin
            if (seen_ff == 2'd0) begin
               first_x_ff <= cur_x_ff;
               first_y_ff <= cur_y_ff;
            end
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load) begin
         cur_x_ff <= req_tdata[COORD_WIDTH-1:0];
         cur_y_ff <= req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
         op_ff    <= req_tuser;
         last_ff  <= req_tlast;
      end
      if (cmd.setup) begin
         hit_ff  <= hit;
         vert_ff <= (ax == bx);
         ax_ff   <= ax;
         dyt_ff  <= DIFF_WIDTH'(test_y_ff) - DIFF_WIDTH'(ay);
         dxw_ff  <= DIFF_WIDTH'(bx) - DIFF_WIDTH'(ax);
         dy_ff   <= DIFF_WIDTH'(by) - DIFF_WIDTH'(ay);
      end
      if (cmd.mul) begin
         prod_ff <= PROD_WIDTH'(dyt_ff) * PROD_WIDTH'(dxw_ff);
      end
      if (cmd.emit) begin
         inside_ff  <= parity_ff & (seen_ff == SEEN_FULL);
         too_few_ff <= (seen_ff != SEEN_FULL);
      end
   end

   assign status.op        = op_ff;
   assign status.last      = last_ff;
   assign status.seen_zero = (seen_ff == 2'd0);
   assign status.edge_hit  = hit_ff;
   assign status.edge_vert = vert_ff;
   assign status.div_done  = div_done;
   assign status.rsp_full  = rsp_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-1){1'b0}}, inside_ff};
   assign rsp_tuser  = too_few_ff;

endmodule

`default_nettype wire

// ----- src/pipc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_ctrl: polygon test sequencer
// Decodes items; per edge: setup, multiply, then divide and compare if needed.
// ----------------------------------------------------------------------------
`default_nettype none

module pipc_ctrl
   import pipc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SETUP,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   state_type    state_ff;
   edge_sel_type sel_ff;
   logic         edge_end;

   // an edge finishes on a miss, a vertical crossing, or a divide result
   assign edge_end = ((state_ff == ST_CHECK) && (!status.edge_hit || status.edge_vert)) ||
                     ((state_ff == ST_DIV) && status.div_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= EDGE_PREV_CUR;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) state_ff <= ST_DECODE;
            end
            ST_DECODE: begin
               if (status.op == OP_START) begin
                  state_ff <= ST_IDLE;
               end else if (status.seen_zero) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  sel_ff   <= EDGE_PREV_CUR;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: state_ff <= ST_MUL;
            ST_MUL:   state_ff <= ST_CHECK;
            ST_CHECK: begin
               if (edge_end) begin
                  state_ff <= (sel_ff == EDGE_PREV_CUR) ? ST_UPDATE : ST_RESULT;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (edge_end) begin
                  state_ff <= (sel_ff == EDGE_PREV_CUR) ? ST_UPDATE : ST_RESULT;
               end
            end
            ST_UPDATE: begin
               if (status.last) begin
                  sel_ff   <= EDGE_CUR_FIRST;
                  state_ff <= ST_SETUP;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_RESULT: begin
               if (!status.rsp_full) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd             = '0;
      cmd.sel         = sel_ff;
      cmd.load        = req_tvalid && (state_ff == ST_IDLE);
      cmd.start_query = (state_ff == ST_DECODE) && (status.op == OP_START);
      cmd.setup       = (state_ff == ST_SETUP);
      cmd.mul         = (state_ff == ST_MUL);
      cmd.toggle      = (state_ff == ST_CHECK) && status.edge_hit && status.edge_vert;
      cmd.div_start   = (state_ff == ST_CHECK) && status.edge_hit && !status.edge_vert;
      cmd.cmp         = (state_ff == ST_DIV) && status.div_done;
      cmd.update      = (state_ff == ST_UPDATE);
      cmd.emit        = (state_ff == ST_RESULT) && !status.rsp_full;
   end

endmodule

`default_nettype wire

// ----- src/point_in_polygon_crossing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_crossing: even-odd ray-casting point-in-polygon test
// Streams a test point and polygon vertices, returns one inside/outside item
// per closed polygon.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: items in. tuser = op (0 start with test point, 1 vertex),
//     tdata = {y, x}, tlast marks the closing vertex. One item in flight.
//   rsp_*: one item per closing vertex. tdata[0] = inside, tuser = too few
//     vertices (then inside is 0).
// Processing (16-bit coordinates):
//   a start item is decoded before the next item is taken.
//   an edge that misses the ray skips the divider; one that needs the
//     crossing x waits on the serial divider (one quotient bit a cycle).
//   a vertex after the first runs one edge; the closing vertex adds the
//     closing edge and the result.
// Reset clears the test point, first/previous vertex, parity and count.
// A stalled result sits in the output register; the next item is still
// taken, and the block only waits if a second result is ready before the
// first has gone out.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_crossing
   import pipc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,   // coord_x, coord_y
   input  wire logic                      req_tuser,   // op
   input  wire logic                      req_tlast,   // last
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,   // inside_res, zero pad
   output logic                           rsp_tuser    // too_few
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: one item at a time, edges run back to back
   pipc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: coordinate state, multiplier, divider, result register
   pipc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- src/pipc_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_check: port-level checks
// Watches the item channels of the polygon test block.
// ----------------------------------------------------------------------------
`default_nettype none

module pipc_check
   import pipc_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input wire logic                      rsp_tuser
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // too few vertices never reports inside
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tuser))
      else $error("inside set on short polygon");

   // one item in flight
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while busy");

   // no result appears in the cycle after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result too early");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind point_in_polygon_crossing pipc_check u_pipc_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ----- test/tb_point_in_polygon_crossing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_crossing: stream testbench for the ray-casting test
// Sends test points and polygons, predicts each inside/too-few verdict in the
// bench and checks every result item in order. Sender and receiver idle at
// random in three of four phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_in_polygon_crossing;
   import pipc_pkg::*;

   localparam int RANDOM_ITEMS  = 700;
   localparam int DRAIN_CYCLES  = 250;    // idle margin at the end of the run
   localparam int STALL_LIMIT   = 5000;   // cycles with no handshake at all
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic      op;
      coord_type x;
      coord_type y;
      logic      last;
   } poly_item_type;

   typedef struct {
      logic inside_res;
      logic too_few;
   } verdict_type;

   // DUT connections, all inputs known from time zero
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;   // coord_x, coord_y
   logic                      req_tuser  = 1'b0; // op
   logic                      req_tlast  = 1'b0; // last
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;         // inside_res, zero pad
   logic                      rsp_tuser;         // too_few

   point_in_polygon_crossing uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stimulus and expectation stores
   poly_item_type pending_q[$];
   verdict_type   verdict_q[$];
   poly_item_type next_item;
   int         total_items    = 0;
   int         items_accepted = 0;
   int         fail_count     = 0;
   int         stall_cycles   = 0;
   int         polygons_seen  = 0;
   int         too_few_seen   = 0;
   int         inside_seen    = 0;
   int         phase_idx;
   int         send_idle_pct;
   int         recv_stall_pct;
   logic       req_took       = 1'b0;

   // Bench copy of the block state
   coord_type  pt_x, pt_y;          // test point
   coord_type  first_x, first_y;    // first vertex of the open polygon
   coord_type  prev_x, prev_y;      // most recent vertex
   logic       parity;
   logic [1:0] vertex_count;        // saturates at SEEN_FULL

   // Does edge a->b cross the ray going right from the test point?
   function automatic logic ray_crosses(coord_type ax, coord_type ay,
                                        coord_type bx, coord_type by);
      longint lo_y, hi_y, hi_x, tx, ty, cross_x;
      tx   = longint'(pt_x);
      ty   = longint'(pt_y);
      lo_y = (ay < by) ? longint'(ay) : longint'(by);
      hi_y = (ay < by) ? longint'(by) : longint'(ay);
      hi_x = (ax < bx) ? longint'(bx) : longint'(ax);
      if (!(ty > lo_y && ty <= hi_y) || tx > hi_x)
         return 1'b0;
      if (ax == bx)
         return 1'b1;                // vertical edge inside the y span
      // SV division truncates toward zero, as the block does
      cross_x = (ty - longint'(ay)) * (longint'(bx) - longint'(ax))
                / (longint'(by) - longint'(ay)) + longint'(ax);
      return (tx <= cross_x);
   endfunction

   // Advance the bench state by one accepted item; queue a verdict on close
   task automatic polygon_step(logic op, coord_type cx, coord_type cy, logic last);
      verdict_type v;
      if (op == OP_START) begin
         pt_x         = cx;
         pt_y         = cy;
         parity       = 1'b0;
         vertex_count = '0;
      end else begin
         if (vertex_count == 2'd0) begin
            first_x = cx;
            first_y = cy;
         end else begin
            parity ^= ray_crosses(prev_x, prev_y, cx, cy);
         end
         prev_x = cx;
         prev_y = cy;
         if (vertex_count != SEEN_FULL)
            vertex_count++;
         if (last) begin
            parity ^= ray_crosses(cx, cy, first_x, first_y);
            if (vertex_count != SEEN_FULL) begin
               v.inside_res = 1'b0;
               v.too_few    = 1'b1;
            end else begin
               v.inside_res = parity;
               v.too_few    = 1'b0;
            end
            verdict_q.push_back(v);
            parity       = 1'b0;
            vertex_count = '0;
         end
      end
   endtask

   task automatic push_item(logic op, int x, int y, logic last);
      poly_item_type it;
      it.op   = op;
      it.x    = coord_type'(x);
      it.y    = coord_type'(y);
      it.last = last;
      pending_q.push_back(it);
   endtask

   function automatic int clamp_coord(int v);
      if (v > 32767)  return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Test point: mostly anywhere, sometimes pinned to an extreme or zero
   function automatic int pick_point();
      case ($urandom_range(0, 7))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic report_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // Driver: new item only when the bus is free or the last one was taken.
   // Phases by progress: none idle, sender 86%, receiver 86%, both 24%.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         phase_idx = (total_items == 0) ? 0 : (items_accepted * 4) / total_items;
         case (phase_idx)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         if (!req_tvalid || req_took) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_item  = pending_q.pop_front();
               req_tdata  <= REQ_DATA_WIDTH'({next_item.y, next_item.x});
               req_tuser  <= next_item.op;
               req_tlast  <= next_item.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted item, check each result item against
   // the oldest verdict, and watch for a stuck block.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         req_took     <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            polygon_step(req_tuser, coord_type'(req_tdata[COORD_WIDTH-1:0]),
                         coord_type'(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
                         req_tlast);
            items_accepted <= items_accepted + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            polygons_seen++;
            if (rsp_tuser)    too_few_seen++;
            if (rsp_tdata[0]) inside_seen++;
            if (verdict_q.size() == 0) begin
               report_failure($sformatf("unexpected result: inside %0b too_few %0b",
                                        rsp_tdata[0], rsp_tuser));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[0] !== want.inside_res || rsp_tuser !== want.too_few)
                  report_failure($sformatf(
                     "mismatch: inside exp %0b got %0b, too_few exp %0b got %0b",
                     want.inside_res, rsp_tdata[0], want.too_few, rsp_tuser));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus build, reset, end of run
   // ------------------------------------------------------------------------
   initial begin
      int base, n, radius, cx, cy, kind;
      pt_x = '0; pt_y = '0; first_x = '0; first_y = '0;
      prev_x = '0; prev_y = '0; parity = 1'b0; vertex_count = '0;

      // Vertices before any start: test point is still zero -> inside
      push_item(OP_VERTEX, -10, -10, 1'b0);
      push_item(OP_VERTEX,  10, -10, 1'b0);
      push_item(OP_VERTEX,  10,  10, 1'b0);
      push_item(OP_VERTEX, -10,  10, 1'b1);
      // Start with last set (ignored), point at the top-right extreme
      push_item(OP_START, 32767, 32767, 1'b1);
      // Full-range square: point sits on the upper y and the larger x
      push_item(OP_VERTEX, -32768, -32768, 1'b0);
      push_item(OP_VERTEX,  32767, -32768, 1'b0);
      push_item(OP_VERTEX,  32767,  32767, 1'b0);
      push_item(OP_VERTEX, -32768,  32767, 1'b1);
      // Point on the lower extreme, triangle reusing it after a close
      push_item(OP_START, -32768, -32768, 1'b0);
      push_item(OP_VERTEX, -5, -5, 1'b0);
      push_item(OP_VERTEX,  5, -5, 1'b0);
      push_item(OP_VERTEX,  0,  5, 1'b1);
      // Too few vertices: one, then two
      push_item(OP_START, 0, 0, 1'b0);
      push_item(OP_VERTEX, 1, 1, 1'b1);
      push_item(OP_VERTEX, 1, 1, 1'b0);
      push_item(OP_VERTEX, 2, 2, 1'b1);
      // Point exactly on a crossing x
      push_item(OP_START, 5, 10, 1'b0);
      push_item(OP_VERTEX,  0,  0, 1'b0);
      push_item(OP_VERTEX, 10, 20, 1'b0);
      push_item(OP_VERTEX, 20,  0, 1'b1);
      // Negative quotient that must truncate toward zero
      push_item(OP_START, 0, 1, 1'b0);
      push_item(OP_VERTEX,  0, 0, 1'b0);
      push_item(OP_VERTEX, -3, 7, 1'b0);
      push_item(OP_VERTEX,  5, 7, 1'b1);

      base = pending_q.size();
      while (pending_q.size() < base + RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            // noise: anything at all
            push_item(1'($urandom_range(0, 1)), pick_point(), pick_point(),
                      1'($urandom_range(0, 1)));
         end else if (kind < 14) begin
            // broken polygon: vertices with no close, cut off by a new start
            push_item(OP_START, pick_point(), pick_point(), 1'($urandom_range(0, 1)));
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               push_item(OP_VERTEX, pick_point(), pick_point(), 1'b0);
         end else begin
            // well-formed polygon around the test point
            cx = pick_point();
            cy = pick_point();
            if ($urandom_range(0, 9) != 0)
               push_item(OP_START, cx, cy, 1'($urandom_range(0, 1)));
            else begin
               cx = int'(pt_x);   // reuse the held point (rough center only)
               cy = int'(pt_y);
            end
            case ($urandom_range(0, 2))
               0:       radius = 8;      // many vertical edges and ties
               1:       radius = 300;
               default: radius = 40000;
            endcase
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            for (int i = 0; i < n; i++)
               push_item(OP_VERTEX,
                         clamp_coord(cx + int'($urandom_range(0, 2 * radius)) - radius),
                         clamp_coord(cy + int'($urandom_range(0, 2 * radius)) - radius),
                         i == n - 1);
         end
      end
      total_items = pending_q.size();

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (items_accepted != total_items || verdict_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdict_q.size() != 0)
         report_failure($sformatf("%0d results never arrived", verdict_q.size()));

      $display("run covered %0d items, %0d polygon results (%0d inside, %0d too few)",
               items_accepted, polygons_seen, inside_seen, too_few_seen);
      $display("mismatches and other failures: %0d", fail_count);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
